FILE: rtl/core/dfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared types and codes for the deduplicating key queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

    localparam int KEY_W      = 64;
    localparam int MS_W       = 32;
    localparam int FUNC_W     = 2;
    localparam int BUDGET_W   = 7;
    localparam int PEND_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_MARK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DRAIN = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_BUDGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESCAN_INTERVAL = 2'd1;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET   = 7'd16;
    localparam logic [MS_W-1:0]     INTERVAL_RESET = 32'd60000;
    localparam logic [BUDGET_W-1:0] MAX_DRAIN      = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN_SETUP,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_TICK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage
`default_nettype wire

FILE: rtl/core/dfq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_in_if
// Request channel: operation code, key and elapsed time.
// ----------------------------------------------------------------------------
interface dfq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] elapsed_ms;

    modport source (output valid, output func, output key, output elapsed_ms, input ready);
    modport sink   (input valid, input func, input key, input elapsed_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dfq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_out_if
// Result channel: drained key, flags and pending count.
// ----------------------------------------------------------------------------
interface dfq_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_key;
    logic        out_valid;
    logic        last;
    logic        accepted;
    logic        rescan_due;
    logic [6:0]  pending_count;

    modport source (output valid, output out_key, output out_valid, output last,
                    output accepted, output rescan_due, output pending_count,
                    input ready);
    modport sink   (input valid, input out_key, input out_valid, input last,
                    input accepted, input rescan_due, input pending_count,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dfq_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dfq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dedup_fifo_with_rescan_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: a mark compares the N waiting keys, one stored key per cycle through the
// single read port, then registers its result; a tick updates the accumulator first;
// a drain reads each key, then emits it when the output register is free (read, then emit).
// One item at a time: the next item is accepted once the last result is registered.
// Reset (synchronous, active low) clears queue pointers, count, accumulator and
// registers to 16 / 60000; key storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// dedup_fifo_with_rescan_timer
// Deduplicating FIFO of 64-bit keys with drain budget and rescan timer.
// ----------------------------------------------------------------------------
module dedup_fifo_with_rescan_timer #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dfq_in_if.sink    i_in,
    dfq_out_if.source o_out,
    dfq_cfg_if.sink   i_cfg
);
    import dfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [BUDGET_W-1:0] r_budget;
    logic [MS_W-1:0]     r_interval;

    t_mem_ctl            w_mem_ctl;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_rd_addr;
    logic [KEY_W-1:0]    w_wr_data;
    logic [KEY_W-1:0]    w_rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget   <= BUDGET_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DRAIN_BUDGET:    r_budget   <= i_cfg.data[BUDGET_W-1:0];
                CFG_RESCAN_INTERVAL: r_interval <= i_cfg.data;
                default: ;
            endcase
        end
    end

    dfq_key_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    dfq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_budget   (r_budget),
        .i_interval (r_interval),
        .o_mem_ctl  (w_mem_ctl),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/dfq_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_key_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfq_key_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic               i_clk,
    input  wire dfq_pkg::t_mem_ctl  i_ctl,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [63:0]        i_wr_data,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic [63:0]             o_rd_data
);
    import dfq_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/core/dfq_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_seq
// Sequencer: duplicate scan with one shared key compare, drain, rescan timer,
// and the result register.
// ----------------------------------------------------------------------------
module dfq_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dfq_in_if.sink                  i_in,
    dfq_out_if.source               o_out,
    input  wire logic [6:0]         i_budget,
    input  wire logic [31:0]        i_interval,
    output dfq_pkg::t_mem_ctl       o_mem_ctl,
    output logic [AW-1:0]           o_wr_addr,
    output logic [63:0]             o_wr_data,
    output logic [AW-1:0]           o_rd_addr,
    input  wire logic [63:0]        i_rd_data
);
    import dfq_pkg::*;

    localparam int NW = (CW > BUDGET_W) ? CW : BUDGET_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_state r_state, n_state;

    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_slot;
    logic [CW-1:0]       r_idx;
    logic                r_cmp_vld;
    logic [BUDGET_W-1:0] r_left;
    logic [MS_W-1:0]     r_acc;
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_W-1:0]    r_key;
    logic [MS_W-1:0]     r_elapsed;
    logic                r_acc_flag;
    logic                r_due_flag;

    logic                r_ovalid;
    logic [KEY_W-1:0]    r_okey;
    logic                r_okey_vld;
    logic                r_olast;
    logic                r_oacc;
    logic                r_odue;
    logic [PEND_W-1:0]   r_opend;

    logic                w_out_free;
    logic                w_take;
    logic                w_match;
    logic                w_issue;
    logic                w_insert;
    logic                w_dup;
    logic                w_emit_key;
    logic                w_emit_res;
    logic [BUDGET_W-1:0] w_bud;
    logic [NW-1:0]       w_cnt_n;
    logic [NW-1:0]       w_bud_n;
    logic [BUDGET_W-1:0] w_n;
    logic [MS_W:0]       w_sum;
    logic [MS_W-1:0]     w_sat;
    logic                w_due;
    logic [AW-1:0]       w_slot_inc;
    logic [AW-1:0]       w_head_inc;
    logic [CW-1:0]       w_count_dec;

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_match    = r_cmp_vld && (i_rd_data == r_key);
    assign w_slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + AW'(1);
    assign w_head_inc = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign w_count_dec = r_count - CW'(1);

    assign w_bud   = (i_budget > MAX_DRAIN) ? MAX_DRAIN : i_budget;
    assign w_cnt_n = NW'(r_count);
    assign w_bud_n = NW'(w_bud);
    assign w_n     = (w_cnt_n < w_bud_n) ? BUDGET_W'(w_cnt_n) : w_bud;

    // saturating accumulate
    assign w_sum = {1'b0, r_acc} + {1'b0, r_elapsed};
    assign w_sat = w_sum[MS_W] ? '1 : w_sum[MS_W-1:0];
    assign w_due = (w_sat >= i_interval);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (i_in.func)
                        FN_MARK: begin
                            if (i_in.key == '0 || r_count >= FULL_CNT) begin
                                n_state = ST_RESULT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_DRAIN: n_state = ST_DRAIN_SETUP;
                        FN_TICK:  n_state = ST_TICK;
                        default:  n_state = ST_RESULT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_dup || w_insert) begin
                    n_state = ST_RESULT;
                end
            end
            ST_DRAIN_SETUP: n_state = (w_n == '0) ? ST_RESULT : ST_DRAIN_RD;
            ST_DRAIN_RD:    n_state = ST_DRAIN_OUT;
            ST_DRAIN_OUT: begin
                if (w_emit_key) begin
                    n_state = (r_left == BUDGET_W'(1)) ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            ST_TICK:        n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_emit_res) begin
                    n_state = ST_IDLE;
                end
            end
            default:        n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_take          = 1'b0;
        w_dup           = 1'b0;
        w_issue         = 1'b0;
        w_insert        = 1'b0;
        w_emit_key      = 1'b0;
        w_emit_res      = 1'b0;
        o_mem_ctl.rd_en = 1'b0;
        o_mem_ctl.wr_en = 1'b0;
        o_rd_addr       = r_slot;
        unique case (r_state)
            ST_IDLE:  w_take = i_in.valid;
            ST_SCAN: begin
                if (w_match) begin
                    w_dup = 1'b1;
                end else if (r_idx != r_count) begin
                    w_issue         = 1'b1;
                    o_mem_ctl.rd_en = 1'b1;
                end else begin
                    w_insert        = 1'b1;
                    o_mem_ctl.wr_en = 1'b1;
                end
            end
            ST_DRAIN_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_head;
            end
            ST_DRAIN_OUT: w_emit_key = w_out_free;
            ST_RESULT:    w_emit_res = w_out_free;
            default: ;
        endcase
    end

    assign o_wr_addr  = r_slot;
    assign o_wr_data  = r_key;
    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_take) begin
                r_func     <= i_in.func;
                r_key      <= i_in.key;
                r_elapsed  <= i_in.elapsed_ms;
                r_slot     <= r_head;
                r_idx      <= '0;
                r_cmp_vld  <= 1'b0;
                r_acc_flag <= 1'b0;
                r_due_flag <= 1'b0;
            end

            // walk the waiting keys, one compare per cycle
            if (w_issue) begin
                r_slot    <= w_slot_inc;
                r_idx     <= r_idx + CW'(1);
                r_cmp_vld <= 1'b1;
            end
            if (w_insert) begin
                r_count    <= r_count + CW'(1);
                r_acc_flag <= 1'b1;
            end

            if (r_state == ST_DRAIN_SETUP) begin
                r_left <= w_n;
            end
            if (w_emit_key) begin
                r_head  <= w_head_inc;
                r_count <= w_count_dec;
                r_left  <= r_left - BUDGET_W'(1);
            end

            if (r_state == ST_TICK) begin
                r_acc      <= w_due ? '0 : w_sat;
                r_due_flag <= w_due;
            end

            if (w_emit_key || w_emit_res) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_emit_key) begin
            r_okey     <= i_rd_data;
            r_okey_vld <= 1'b1;
            r_olast    <= (r_left == BUDGET_W'(1));
            r_oacc     <= 1'b0;
            r_odue     <= 1'b0;
            r_opend    <= PEND_W'(w_count_dec);
        end else if (w_emit_res) begin
            r_okey     <= '0;
            r_okey_vld <= 1'b0;
            r_olast    <= 1'b1;
            r_oacc     <= r_acc_flag && (r_func == FN_MARK);
            r_odue     <= r_due_flag && (r_func == FN_TICK);
            r_opend    <= PEND_W'(r_count);
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_key       = r_okey;
    assign o_out.out_valid     = r_okey_vld;
    assign o_out.last          = r_olast;
    assign o_out.accepted      = r_oacc;
    assign o_out.rescan_due    = r_odue;
    assign o_out.pending_count = r_opend;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("pending count above queue depth");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |-> (r_count < FULL_CNT) && (r_key != '0))
        else $error("insert into full queue or of zero key");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN_OUT) |-> (r_count != '0) && (r_left != '0))
        else $error("drain pop from empty queue");

    a_due_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && w_due) |=> (r_acc == '0) && r_due_flag)
        else $error("rescan due without accumulator clear");

endmodule
`default_nettype wire
